// ===== rtl/core/md5_message_digest_assert.svh =====
// Assertion macros for the MD5 digest core.
// Used by the top level only; needs no package.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication.
`define MD5_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MD5_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/md5_pkg.sv =====
// Shared types and constants of the MD5 digest core.
// No dependencies.
package md5_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ADDR_BITS = $clog2(BLOCK_WORDS);
   localparam int unsigned ROUNDS = 64;
   localparam int unsigned ROUND_BITS = $clog2(ROUNDS);

   localparam logic [3:0][WORD_BITS-1:0] MD5_INIT =
      {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_PREFETCH,
      ST_ROUND,
      ST_CHAIN,
      ST_EMIT
   } md5_state_type;

   typedef enum logic [1:0] {
      PAD_MARK,
      PAD_ZERO,
      PAD_LEN
   } md5_pad_type;

   typedef struct packed {
      logic                  load;
      logic                  step;
      logic [ROUND_BITS-1:0] rnd;
   } md5_round_ctrl_type;

   // Message word used by a round; only the low four bits of each product matter.
   function automatic logic [ADDR_BITS-1:0] md5_msg_index(input logic [ROUND_BITS-1:0] r);
      logic [ADDR_BITS-1:0] rl;
      logic [ADDR_BITS-1:0] idx;
      rl = r[ADDR_BITS-1:0];
      case (r[ROUND_BITS-1:ROUND_BITS-2])
         2'd0: idx = rl;
         2'd1: idx = ADDR_BITS'(rl * 4'd5 + 4'd1);
         2'd2: idx = ADDR_BITS'(rl * 4'd3 + 4'd5);
         default: idx = ADDR_BITS'(rl * 4'd7);
      endcase
      return idx;
   endfunction

endpackage

// ===== rtl/core/md5_message_digest.sv =====
// MD5 digest core; uses md5_pkg, md5_block_ram, md5_round and md5_message_digest_assert.svh.
// Byte requests are taken only while the core is idle; a full 64-byte block then stalls
// requests through memory read-ahead, 64 rounds and chaining add. A message end adds the
// pad bytes (up to 72 over two blocks), one or two block compressions, then 16 digest
// responses. Reset is synchronous: control, length and chaining words return to initial
// values; the block memory is not cleared, each word is written first.
`include "md5_message_digest_assert.svh"

module md5_message_digest import md5_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] byte_present
   input  logic       req_tlast,   // message_end
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] digest_byte
   output logic       rsp_tlast    // digest_last
);

   md5_state_type             state_ff, state_in;
   md5_pad_type               pad_ff, pad_in;
   logic [5:0]                pos_ff, pos_in;        // next byte lane in the block
   logic [23:0]               word_ff, word_in;      // lower three bytes of word in progress
   logic [63:0]               bit_len_ff, bit_len_in;
   logic [3:0][WORD_BITS-1:0] chain_ff, chain_in;
   logic [ROUND_BITS-1:0]     rnd_ff, rnd_in;
   logic [2:0]                len_idx_ff, len_idx_in;
   logic                      pad_on_ff, pad_on_in;  // message end seen, padding under way
   logic                      pad_done_ff, pad_done_in;
   logic [3:0]                out_idx_ff, out_idx_in;

   logic                      put_en;
   logic [7:0]                put_byte;
   logic                      wr_en;
   logic [WORD_BITS-1:0]      wr_data;
   logic [ADDR_BITS-1:0]      rd_addr;
   logic [WORD_BITS-1:0]      rd_data;
   md5_round_ctrl_type        round_ctrl;
   logic [3:0][WORD_BITS-1:0] round_words;
   logic                      req_take;
   logic                      len_phase;

   assign req_take  = req_tvalid && req_tready;
   // length bytes start once the zero fill has reached lane 56
   assign len_phase = (pad_ff == PAD_LEN) || ((pad_ff == PAD_ZERO) && (pos_ff == LEN_POS));

   always_comb begin
      state_in    = state_ff;
      pad_in      = pad_ff;
      pos_in      = pos_ff;
      word_in     = word_ff;
      bit_len_in  = bit_len_ff;
      chain_in    = chain_ff;
      rnd_in      = rnd_ff;
      len_idx_in  = len_idx_ff;
      pad_on_in   = pad_on_ff;
      pad_done_in = pad_done_ff;
      out_idx_in  = out_idx_ff;
      put_en      = 1'b0;
      put_byte    = '0;
      rd_addr     = '0;
      round_ctrl  = '{load: 1'b0, step: 1'b0, rnd: rnd_ff};
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take) begin
               if (req_tuser) begin
                  put_en     = 1'b1;
                  put_byte   = req_tdata;
                  bit_len_in = bit_len_ff + 64'd8;
               end
               if (req_tlast) begin
                  pad_on_in   = 1'b1;
                  pad_done_in = 1'b0;
                  pad_in      = PAD_MARK;
                  len_idx_in  = '0;
                  state_in    = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            put_en = 1'b1;
            if (pad_ff == PAD_MARK) begin
               put_byte = PAD_MARK_BYTE;
               pad_in   = PAD_ZERO;
            end else if (len_phase) begin
               put_byte   = bit_len_ff[{len_idx_ff, 3'b000} +: 8];
               pad_in     = PAD_LEN;
               len_idx_in = len_idx_ff + 3'd1;
               if (&len_idx_ff) begin
                  pad_done_in = 1'b1;
               end
            end else begin
               put_byte = 8'h00;
            end
         end
         ST_PREFETCH: begin
            round_ctrl.load = 1'b1;
            rd_addr         = md5_msg_index('0);
            rnd_in          = '0;
            state_in        = ST_ROUND;
         end
         ST_ROUND: begin
            round_ctrl.step = 1'b1;
            // read ahead the word for the next round
            rd_addr         = md5_msg_index(rnd_ff + 1'b1);
            rnd_in          = rnd_ff + 1'b1;
            if (&rnd_ff) begin
               state_in = ST_CHAIN;
            end
         end
         ST_CHAIN: begin
            for (int i = 0; i < 4; i++) begin
               chain_in[i] = chain_ff[i] + round_words[i];
            end
            if (!pad_on_ff) begin
               state_in = ST_IDLE;
            end else if (pad_done_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               out_idx_in = out_idx_ff + 4'd1;
               if (&out_idx_ff) begin
                  chain_in   = MD5_INIT;
                  bit_len_in = '0;
                  pad_on_in  = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // byte lane write; a full word goes to memory, a full block starts compression
      wr_en   = 1'b0;
      wr_data = {put_byte, word_ff};
      if (put_en) begin
         pos_in = pos_ff + 6'd1;
         case (pos_ff[1:0])
            2'd0: word_in[7:0]   = put_byte;
            2'd1: word_in[15:8]  = put_byte;
            2'd2: word_in[23:16] = put_byte;
            default: wr_en = 1'b1;
         endcase
         if (&pos_ff) begin
            state_in = ST_PREFETCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pad_ff      <= PAD_MARK;
         pos_ff      <= '0;
         bit_len_ff  <= '0;
         chain_ff    <= MD5_INIT;
         rnd_ff      <= '0;
         len_idx_ff  <= '0;
         pad_on_ff   <= 1'b0;
         pad_done_ff <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         pad_ff      <= pad_in;
         pos_ff      <= pos_in;
         bit_len_ff  <= bit_len_in;
         chain_ff    <= chain_in;
         rnd_ff      <= rnd_in;
         len_idx_ff  <= len_idx_in;
         pad_on_ff   <= pad_on_in;
         pad_done_ff <= pad_done_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   // word assembly is payload only
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   md5_block_ram u_block_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[5:2]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   md5_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (round_ctrl),
      .chain       (chain_ff),
      .msg_word    (rd_data),
      .round_words (round_words)
   );

   assign rsp_tdata = chain_ff[out_idx_ff[3:2]][{out_idx_ff[1:0], 3'b000} +: 8];
   assign rsp_tlast = &out_idx_ff;

   // requests and digest bytes never overlap
   `MD5_ASSERT_NOW(a_no_overlap, clock, reset, req_tready, !rsp_tvalid,
      "request taken during digest output")
   // last round is followed by the chaining add
   `MD5_ASSERT_NEXT(a_round_end, clock, reset, (state_ff == ST_ROUND) && (&rnd_ff),
      state_ff == ST_CHAIN, "round count overrun")
   // digest output starts on a block boundary
   `MD5_ASSERT_NOW(a_emit_aligned, clock, reset, rsp_tvalid,
      (pos_ff == 6'd0) && pad_done_ff, "digest before padding complete")
   // after the last digest byte the next message starts clean
   `MD5_ASSERT_NEXT(a_restart, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      (state_ff == ST_IDLE) && (bit_len_ff == 64'd0) && (chain_ff == MD5_INIT),
      "state not restarted")

endmodule

// ===== rtl/core/md5_block_ram.sv =====
// Message block buffer: 16 x 32 synchronous memory, one write port,
// one read port with registered data. Depends on md5_pkg.
module md5_block_ram import md5_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [BLOCK_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/md5_round.sv =====
// MD5 round unit: working words a..d and one round per step.
// Depends on md5_pkg.
module md5_round import md5_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  md5_round_ctrl_type            ctrl,
   input  logic [3:0][WORD_BITS-1:0]     chain,
   input  logic [WORD_BITS-1:0]          msg_word,
   output logic [3:0][WORD_BITS-1:0]     round_words
);

   localparam logic [WORD_BITS-1:0] K_TABLE [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   logic [3:0][WORD_BITS-1:0] rw_ff;
   logic [3:0][WORD_BITS-1:0] rw_in;
   logic [WORD_BITS-1:0]      f_val;
   logic [WORD_BITS-1:0]      sum;
   logic [2*WORD_BITS-1:0]    rot_dbl;
   logic [4:0]                shamt;

   // rotate amount: by quarter (r[5:4]) and lane (r[1:0])
   always_comb begin
      case ({ctrl.rnd[5:4], ctrl.rnd[1:0]})
         4'h0: shamt = 5'd7;   4'h1: shamt = 5'd12;  4'h2: shamt = 5'd17;  4'h3: shamt = 5'd22;
         4'h4: shamt = 5'd5;   4'h5: shamt = 5'd9;   4'h6: shamt = 5'd14;  4'h7: shamt = 5'd20;
         4'h8: shamt = 5'd4;   4'h9: shamt = 5'd11;  4'ha: shamt = 5'd16;  4'hb: shamt = 5'd23;
         4'hc: shamt = 5'd6;   4'hd: shamt = 5'd10;  4'he: shamt = 5'd15;  default: shamt = 5'd21;
      endcase
   end

   always_comb begin
      case (ctrl.rnd[5:4])
         2'd0: f_val = (rw_ff[1] & rw_ff[2]) | (~rw_ff[1] & rw_ff[3]);
         2'd1: f_val = (rw_ff[3] & rw_ff[1]) | (~rw_ff[3] & rw_ff[2]);
         2'd2: f_val = rw_ff[1] ^ rw_ff[2] ^ rw_ff[3];
         default: f_val = rw_ff[2] ^ (rw_ff[1] | ~rw_ff[3]);
      endcase
      sum     = f_val + rw_ff[0] + K_TABLE[ctrl.rnd] + msg_word;
      rot_dbl = {sum, sum} << shamt;
      rw_in   = rw_ff;
      if (ctrl.load) begin
         rw_in = chain;
      end else if (ctrl.step) begin
         rw_in[0] = rw_ff[3];
         rw_in[1] = rw_ff[1] + rot_dbl[2*WORD_BITS-1:WORD_BITS];
         rw_in[2] = rw_ff[1];
         rw_in[3] = rw_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_ff <= '0;
      end else begin
         rw_ff <= rw_in;
      end
   end

   assign round_words = rw_ff;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for md5_message_digest: streams byte requests, predicts the
// 16 digest bytes of every message with an MD5 predictor of its own and checks responses.
// Depends only on the md5_message_digest RTL and the files it pulls in.
`timescale 1ns / 100ps

module tb_top;

   // MD5 initial chaining words and padding layout
   localparam logic [31:0] CHAIN_INIT_A = 32'h67452301;
   localparam logic [31:0] CHAIN_INIT_B = 32'hefcdab89;
   localparam logic [31:0] CHAIN_INIT_C = 32'h98badcfe;
   localparam logic [31:0] CHAIN_INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_FIRST    = 8'h80;
   localparam int          LEN_LANE     = 56;
   localparam int          BLOCK_BYTES  = 64;

   // per-round additive constants, element 0 first
   localparam logic [0:63][31:0] SINE_ADD = {
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int RANDOM_REQUESTS = 480;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 300;

   // one byte request as offered on the input side
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
      logic       wait_idle;     // sender holds this request until no digest is outstanding
   } byte_req_type;

   // one digest response as it should arrive
   typedef struct packed {
      logic [7:0] digest_byte;
      logic       digest_last;
   } digest_rsp_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tuser = 1'b0;    // [0] byte_present
   logic       req_tlast = 1'b0;    // message_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] digest_byte
   logic       rsp_tlast;           // digest_last

   byte_req_type   stim_q[$];       // requests not yet offered
   digest_rsp_type digest_due_q[$]; // digest bytes predicted and not yet seen

   // predictor state
   logic [31:0] msg_block [16];
   logic [31:0] chain [4];
   int          lane_pos;
   logic [63:0] msg_bits;

   int err_count = 0;
   int stim_counted = 0;
   int n_messages = 0;
   int n_bytes = 0;
   int n_empty = 0;
   int n_checked = 0;
   int n_drains = 0;
   int digests_seen = 0;
   int req_gap_left = 0;
   int req_calm = 0;
   int rsp_gap_left = 0;
   int rsp_calm = 0;
   bit long_hold_done = 1'b0;

   md5_message_digest DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // rotate amount: four values per group of sixteen rounds
   function automatic int unsigned round_shift(input int r);
      int q;
      q = r / 16;
      case (r % 4)
         0: return (q == 0) ? 7  : (q == 1) ? 5  : (q == 2) ? 4  : 6;
         1: return (q == 0) ? 12 : (q == 1) ? 9  : (q == 2) ? 11 : 10;
         2: return (q == 0) ? 17 : (q == 1) ? 14 : (q == 2) ? 16 : 15;
         default: return (q == 0) ? 22 : (q == 1) ? 20 : (q == 2) ? 23 : 21;
      endcase
   endfunction

   task automatic md5_compress_block();
      logic [31:0] a, b, c, d, f, nb;
      int g;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin f = (b & c) | (~b & d); g = r; end
            1: begin f = (d & b) | (~d & c); g = (5 * r + 1) % 16; end
            2: begin f = b ^ c ^ d;          g = (3 * r + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
         endcase
         f = f + a + SINE_ADD[r] + msg_block[g];
         nb = b + rotl32(f, round_shift(r));
         a = d;
         d = c;
         c = b;
         b = nb;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
   endtask

   // little-endian byte lane fill; a full block is folded into the chain
   task automatic md5_put_byte(input logic [7:0] v);
      msg_block[lane_pos / 4][(lane_pos % 4) * 8 +: 8] = v;
      lane_pos = (lane_pos + 1) % BLOCK_BYTES;
      if (lane_pos == 0)
         md5_compress_block();
   endtask

   task automatic md5_restart();
      chain[0] = CHAIN_INIT_A;
      chain[1] = CHAIN_INIT_B;
      chain[2] = CHAIN_INIT_C;
      chain[3] = CHAIN_INIT_D;
      lane_pos = 0;
      msg_bits = '0;
   endtask

   // absorb one accepted request; a message end pads and queues the 16 digest bytes
   task automatic md5_take_request(input logic [7:0] data, input logic present,
                                   input logic last);
      logic [63:0] len_bits;
      digest_rsp_type rsp;
      if (present) begin
         md5_put_byte(data);
         msg_bits += 64'd8;
         n_bytes++;
      end else if (!last) begin
         n_empty++;
      end
      if (last) begin
         len_bits = msg_bits;
         md5_put_byte(PAD_FIRST);
         while (lane_pos != LEN_LANE)
            md5_put_byte(8'h00);
         for (int i = 0; i < 8; i++)
            md5_put_byte(len_bits[8 * i +: 8]);
         for (int i = 0; i < 16; i++) begin
            rsp.digest_byte = chain[i / 4][(i % 4) * 8 +: 8];
            rsp.digest_last = (i == 15);
            digest_due_q = {digest_due_q, rsp};
         end
         n_messages++;
         md5_restart();
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   // idle length: mostly none or short, a few long, now and then a run with no idling
   function automatic int draw_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_req(input logic [7:0] data, input logic present, input logic last,
                           input logic hold);
      byte_req_type item;
      item.data_byte = data;
      item.byte_present = present;
      item.message_end = last;
      item.wait_idle = hold;
      stim_q = {stim_q, item};
      stim_counted++;
   endtask

   // random message; the end flag rides on the last byte or on a separate empty request
   task automatic push_message(input int len, input bit end_on_byte, input bit hold);
      bit gate;
      gate = hold;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 4) begin
            push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, gate);
            gate = 1'b0;
         end
         push_req(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1), gate);
         gate = 1'b0;
      end
      if (len == 0 || !end_on_byte)
         push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, gate);
   endtask

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin : drive_requests
      byte_req_type nxt;
      bit take;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         take = req_tvalid && req_tready;
         if (take) begin
            md5_take_request(req_tdata, req_tuser, req_tlast);
            req_gap_left = draw_gap(req_calm);
         end
         // a new request is chosen only once the current one is gone
         if (take || !req_tvalid) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_tvalid <= 1'b0;
            end else if (stim_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (stim_q[0].wait_idle && digest_due_q.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               nxt = stim_q.pop_front();
               if (nxt.wait_idle)
                  n_drains++;
               req_tvalid <= 1'b1;
               req_tdata <= nxt.data_byte;
               req_tuser <= nxt.byte_present;
               req_tlast <= nxt.message_end;
            end
         end
      end
   end

   // ---------------------------------------------------------------- response monitor

   always @(posedge clock) begin : watch_digest
      digest_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_due_q.size() == 0) begin
               err_count++;
               $error("unexpected response: digest_byte %02h digest_last %0b",
                      rsp_tdata, rsp_tlast);
            end else begin
               want = digest_due_q.pop_front();
               n_checked++;
               if (rsp_tdata !== want.digest_byte) begin
                  err_count++;
                  $error("digest_byte mismatch: expected %02h, actual %02h",
                         want.digest_byte, rsp_tdata);
               end
               if (rsp_tlast !== want.digest_last) begin
                  err_count++;
                  $error("digest_last mismatch: expected %0b, actual %0b",
                         want.digest_last, rsp_tlast);
               end
            end
            if (rsp_tlast === 1'b1)
               digests_seen++;
            rsp_gap_left = draw_gap(rsp_calm);
         end
         // one long back-pressure window while the sender keeps pushing
         if (!long_hold_done && rsp_tvalid && digests_seen >= 2) begin
            long_hold_done = 1'b1;
            rsp_gap_left = LONG_HOLD_CYCLES;
         end
         if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- sequence and end

   initial begin : run_sequence
      int msg_no;
      int len;
      int roll;
      int edge_lens [8];
      edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
      md5_restart();

      // directed: empty message, single extreme bytes, empty items, end with and
      // without a byte, a drained start, back-to-back messages
      push_req(8'h5a, 1'b0, 1'b1, 1'b0);
      push_req(8'h00, 1'b1, 1'b1, 1'b0);
      push_req(8'hff, 1'b1, 1'b0, 1'b0);
      push_req(8'ha5, 1'b0, 1'b0, 1'b0);
      push_req(8'h3c, 1'b0, 1'b1, 1'b0);
      push_req(8'h61, 1'b1, 1'b0, 1'b1);
      push_req(8'h62, 1'b1, 1'b0, 1'b0);
      push_req(8'h63, 1'b1, 1'b1, 1'b0);
      push_req(8'h00, 1'b0, 1'b1, 1'b0);
      push_req(8'h80, 1'b1, 1'b0, 1'b0);
      push_req(8'h7f, 1'b1, 1'b1, 1'b0);

      // random messages: many short, some on the one/two padding block boundaries
      msg_no = 0;
      while (stim_counted < RANDOM_REQUESTS) begin
         roll = $urandom_range(0, 99);
         if (roll < 50)
            len = $urandom_range(0, 12);
         else if (roll < 75)
            len = edge_lens[$urandom_range(0, 7)];
         else
            len = $urandom_range(13, 80);
         push_message(len, 1'($urandom_range(0, 1)), (msg_no % 7) == 4);
         msg_no++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_tvalid || digest_due_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d messages: %0d message bytes, %0d empty requests.",
               n_messages, n_bytes, n_empty);
      $display("%0d digest bytes checked, %0d drained pauses, long response hold-off %0s.",
               n_checked, n_drains, long_hold_done ? "applied" : "not reached");
      if (err_count == 0 && digest_due_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog: far above the slowest legal run
   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
